// ----- src/brtc_pkg.sv -----
// package for the block read tile cache
// holds status, action, pending and register codes plus shared cell types
`default_nettype none
package brtc_pkg;
  localparam int unsigned MaxTiles    = 32;
  localparam int unsigned MaxTileLog2 = 5;
  localparam int unsigned AgeLimit    = 2000000000;

  typedef enum logic [2:0] {
    ST_HIT = 3'd0, ST_FILL = 3'd1, ST_DIRECT = 3'd2, ST_OK = 3'd3,
    ST_ROLL = 3'd4, ST_MISHAP = 3'd5, ST_ORDER = 3'd6
  } status_t;

  localparam logic [1:0] ACT_READ = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_DIRECT = 2'd2;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_FILL = 2'd1;
  localparam logic [1:0] PEND_DIRECT = 2'd2;

  localparam logic [1:0] REG_DISP = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_TILES = 2'd2;
  localparam logic [1:0] REG_SIZE = 2'd3;

  // search token travelling down the cell row
  typedef struct packed {
    logic        hit;
    logic        inv;
    logic [30:0] oldest;
  } scan_t;

  // command broadcast to all cells
  typedef struct packed {
    logic        clr_ages;
    logic        set_age;
    logic        set_tag;
    logic        kill_tag;
    logic        set_aerr;
    logic        set_err;
    logic [30:0] age;
    logic [31:0] tag;
    logic [31:0] err;
  } cmd_t;
endpackage
`default_nettype wire

// ----- src/block_read_tile_cache_unit.sv -----
// a rollover or out-of-order transaction goes straight to the output; an
// outcome passes decode and apply; a read request also walks the tile row
// one cell per cycle for the tag and oldest age, stopping at a hit or the last tile.
// one transaction at a time; result held in an output register.
// rst (synchronous, active high) invalidates all tiles, clears ages, errors
// and pending state, and loads register defaults.
`default_nettype none
module block_read_tile_cache_unit
  import brtc_pkg::*;
#(
  parameter int unsigned MAX_TILES     = MaxTiles,
  parameter int unsigned MAX_TILE_LOG2 = MaxTileLog2,
  parameter int unsigned AGE_LIMIT     = AgeLimit
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // action[1:0], block_address[33:2], read_ok[34]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // status[2:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_DEC = 5'b00100,
    S_APPLY = 5'b01000, S_OUT = 5'b10000
  } state_t;
  state_t state;

  logic [31:0] disp;
  logic [1:0]  mode;
  logic [5:0]  tiles;
  logic [2:0]  lg;

  logic [1:0]  action;
  logic        ok;
  logic [31:0] lba, aligned;
  logic [2:0]  status;
  logic [1:0]  pkind;
  logic [TW-1:0] ptile;
  logic [31:0] paddr, paligned;
  logic [30:0] age_counter;
  logic [CW-1:0] pos, n;
  scan_t       tok;
  logic        found_hit;
  logic [TW-1:0] hit_t, vic_t, tsel;
  cmd_t        cmd;
  logic        step;
  logic [31:0] err_key;

  scan_t scan_o [MAX_TILES];
  logic  hh [MAX_TILES];
  logic  hv [MAX_TILES];
  logic  am [MAX_TILES];
  logic  em [MAX_TILES];

  // effective tile count and size
  always_comb begin
    n = (tiles == 6'd0) ? CW'(1)
      : ({26'd0, tiles} > 32'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(tiles);
  end

  logic [3:0] lge;
  assign lge = ({1'b0, lg} > 4'(MAX_TILE_LOG2)) ? 4'(MAX_TILE_LOG2) : {1'b0, lg};

  // one cell active per scan cycle; token carried in tok
  logic [TW-1:0] pidx;
  assign pidx = TW'(pos);

  // failed direct reads are matched on the pending address for outcomes
  assign err_key = (action == ACT_READ) ? lba : paddr;

  genvar g;
  generate
    for (g = 0; g < MAX_TILES; g++) begin : g_cell
      brtc_cell u_cell (
        .clk(clk), .rst(rst),
        .sel(tsel == TW'(g)),
        .active(state == S_SCAN ? pidx == TW'(g) : (CW'(g) < n)),
        .cmd(cmd), .step(step),
        .key(aligned), .lba(err_key),
        .scan_in(tok), .scan_out(scan_o[g]),
        .here_hit(hh[g]), .here_vic(hv[g]),
        .aerr_match(am[g]), .err_match(em[g])
      );
    end
  endgenerate

  scan_t tok_next;
  logic  cur_hit, cur_vic, cur_am, cur_em;
  always_comb begin
    tok_next = scan_o[pidx];
    cur_hit  = hh[pidx];
    cur_vic  = hv[pidx];
    cur_am   = am[tsel];
    cur_em   = em[tsel];
  end

  logic [32:0] sum;
  logic [30:0] age_inc;
  logic        age_wrap;
  logic        roll;
  assign sum      = {1'b0, s_tdata[33:2]} + {1'b0, disp};
  assign age_inc  = age_counter + 31'd1;
  assign age_wrap = {1'b0, age_inc} >= 32'(AGE_LIMIT);
  assign roll     = (mode == 2'd1 && sum[32]) || (mode == 2'd2 && s_tdata[33:2] < disp);

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {5'd0, status};

  // command decode in S_APPLY
  always_comb begin
    cmd  = '0;
    step = (state == S_APPLY);
    tsel = (state == S_APPLY && action == ACT_READ) ? (found_hit ? hit_t : vic_t) : ptile;
    cmd.age = age_wrap ? 31'd1 : age_inc;
    cmd.clr_ages = age_wrap;
    cmd.tag = (action == ACT_READ) ? aligned : paligned;
    cmd.err = paddr;
    if (action == ACT_READ) begin
      if (found_hit) cmd.set_age = 1'b1;
      else begin
        cmd.kill_tag = 1'b1;
        cmd.clr_ages = 1'b0;
        if (cur_am) cmd.set_aerr = 1'b1;
      end
    end else if (action == ACT_FILL) begin
      if (ok) begin
        cmd.set_tag = 1'b1;
        cmd.set_age = 1'b1;
      end else begin
        cmd.clr_ages = 1'b0;
        cmd.set_aerr = 1'b1;
      end
    end else begin
      cmd.clr_ages = 1'b0;
      if (!ok) cmd.set_err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      disp <= '0; mode <= '0; tiles <= 6'd32; lg <= 3'd5;
      pkind <= PEND_NONE; ptile <= '0; paddr <= '0; paligned <= '0;
      age_counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_DISP:  disp  <= cfg_data;
              REG_MODE:  mode  <= cfg_data[1:0];
              REG_TILES: tiles <= cfg_data[5:0];
              REG_SIZE:  lg    <= cfg_data[2:0];
              default: ;
            endcase
          end else if (s_tvalid) begin
            action <= s_tdata[1:0];
            ok     <= s_tdata[34];
            if (s_tdata[1:0] == ACT_READ && pkind == PEND_NONE) begin
              if (mode == 2'd1) lba <= sum[31:0];
              else if (mode == 2'd2) lba <= s_tdata[33:2] - disp;
              else lba <= s_tdata[33:2];
              if (roll) begin
                status <= ST_ROLL;
                state  <= S_OUT;
              end else state <= S_DEC;
            end else if (s_tdata[1:0] == ACT_READ || s_tdata[1:0] != pkind) begin
              lba    <= s_tdata[33:2];
              status <= ST_ORDER;
              state  <= S_OUT;
            end else begin
              lba   <= s_tdata[33:2];
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          aligned <= lba & ~((32'd1 << lge) - 32'd1);
          if (action == ACT_READ) begin
            pos <= '0;
            tok <= '{hit: 1'b0, inv: 1'b0, oldest: 31'(AGE_LIMIT)};
            found_hit <= 1'b0;
            vic_t <= '0;
            state <= S_SCAN;
          end else state <= S_APPLY;
        end
        S_SCAN: begin
          tok <= tok_next;
          if (cur_hit) begin
            found_hit <= 1'b1;
            hit_t <= pidx;
          end
          if (cur_vic) vic_t <= pidx;
          if (cur_hit || pos + CW'(1) >= n) state <= S_APPLY;
          pos <= pos + CW'(1);
        end
        S_APPLY: begin
          state <= S_OUT;
          if (cmd.set_age) age_counter <= cmd.age;
          if (action == ACT_READ) begin
            if (found_hit) status <= ST_HIT;
            else begin
              ptile <= vic_t; paddr <= lba; paligned <= aligned;
              if (cur_am) begin
                if (cur_em) begin
                  status <= ST_MISHAP; pkind <= PEND_NONE;
                end else begin
                  status <= ST_DIRECT; pkind <= PEND_DIRECT;
                end
              end else begin
                status <= ST_FILL; pkind <= PEND_FILL;
              end
            end
          end else if (action == ACT_FILL) begin
            if (ok) begin
              status <= ST_OK; pkind <= PEND_NONE;
            end else if (cur_em) begin
              status <= ST_MISHAP; pkind <= PEND_NONE;
            end else begin
              status <= ST_DIRECT; pkind <= PEND_DIRECT;
            end
          end else begin
            pkind  <= PEND_NONE;
            status <= ok ? ST_OK : ST_MISHAP;
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/brtc_cell.sv -----
// one cache tile: tag, age and remembered failures
// uses brtc_pkg; passes its updated scan token back to the unit's token register
`default_nettype none
module brtc_cell
  import brtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sel,
  input  wire logic        active,
  input  wire cmd_t        cmd,
  input  wire logic        step,
  input  wire logic [31:0] key,
  input  wire logic [31:0] lba,
  input  wire scan_t       scan_in,
  output scan_t            scan_out,
  output logic             here_hit,
  output logic             here_vic,
  output logic             aerr_match,
  output logic             err_match
);
  logic        tag_valid, err_valid, aerr_valid;
  logic [31:0] tag, last_err, last_aerr;
  logic [30:0] age;

  always_comb begin
    here_hit = 1'b0;
    here_vic = 1'b0;
    scan_out = scan_in;
    if (active && !scan_in.hit) begin
      if (tag_valid && tag == key) begin
        here_hit = 1'b1;
        scan_out.hit = 1'b1;
      end else if (!scan_in.inv) begin
        if (!tag_valid) begin
          here_vic = 1'b1;
          scan_out.inv = 1'b1;
        end else if (age < scan_in.oldest) begin
          here_vic = 1'b1;
          scan_out.oldest = age;
        end
      end
    end
    aerr_match = aerr_valid && last_aerr == key;
    err_match  = err_valid && last_err == lba;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid  <= 1'b0;
      err_valid  <= 1'b0;
      aerr_valid <= 1'b0;
      age        <= '0;
    end else if (step) begin
      // the touched tile takes the new stamp even when all ages clear
      if (sel && cmd.set_age) age <= cmd.age;
      else if (cmd.clr_ages && active) age <= '0;
      if (sel) begin
        if (cmd.kill_tag) tag_valid <= 1'b0;
        if (cmd.set_tag) begin
          tag_valid <= 1'b1;
          tag       <= cmd.tag;
        end
        if (cmd.set_aerr) begin
          aerr_valid <= 1'b1;
          last_aerr  <= cmd.tag;
        end
        if (cmd.set_err) begin
          err_valid <= 1'b1;
          last_err  <= cmd.err;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/brtc_checker.sv -----
// port-level checks for the block read tile cache
// bound to block_read_tile_cache_unit; uses no package
`default_nettype none
module brtc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7 && m_tdata[7:3] == 5'd0)
    else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken with result pending");
endmodule

bind block_read_tile_cache_unit brtc_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for block_read_tile_cache_unit
// predicts every status in its own tile cache copy; uses brtc_pkg for codes
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import brtc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // action[1:0], block_address[33:2], read_ok[34]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // status[2:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  block_read_tile_cache_unit dut (.*);

  localparam int unsigned CycleLimit = 600000;
  localparam logic [1:0]  ActNone = 2'd3;

  // predictor copy of the cache
  logic [31:0] disp_r, mode_r, tiles_r, size_r;
  logic [31:0] tag_m [MaxTiles];
  logic        tag_ok [MaxTiles];
  logic [31:0] age_m [MaxTiles];
  logic [31:0] err_m [MaxTiles];
  logic        err_ok [MaxTiles];
  logic [31:0] aerr_m [MaxTiles];
  logic        aerr_ok [MaxTiles];
  logic [31:0] age_cnt;
  logic [1:0]  pend_kind;
  int unsigned pend_tile;
  logic [31:0] pend_addr, pend_aligned;

  status_t     status_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned results_seen = 0;
  int unsigned results_drawn = 0;
  logic        no_idle = 1'b0;
  logic [31:0] addr_pool [48];

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", m_tdata[2:0]);
      end else begin
        if (m_tdata[2:0] !== status_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: expected %0d got %0d", status_q[0], m_tdata[2:0]);
        end
        void'(status_q.pop_front());
      end
    end
  end

  // receiver with per-result stall and long hold-off
  always @(negedge clk) begin
    if (results_drawn != results_seen) begin
      results_drawn = results_seen;
      stall_left = no_idle ? 0 : $urandom_range(0, 5);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int unsigned used_tiles();
    if (tiles_r < 1) return 1;
    if (tiles_r > MaxTiles) return MaxTiles;
    return tiles_r;
  endfunction

  function automatic void touch_age(int unsigned t);
    age_cnt++;
    if (age_cnt >= AgeLimit) begin
      for (int unsigned i = 0; i < used_tiles(); i++) age_m[i] = 0;
      age_cnt = 1;
    end
    age_m[t] = age_cnt;
  endfunction

  function automatic status_t fill_failed(int unsigned t, logic [31:0] lba,
                                          logic [31:0] aligned);
    aerr_m[t] = aligned;
    aerr_ok[t] = 1'b1;
    if (err_ok[t] && err_m[t] == lba) begin
      pend_kind = PEND_NONE;
      return ST_MISHAP;
    end
    pend_kind = PEND_DIRECT;
    pend_tile = t;
    pend_addr = lba;
    pend_aligned = aligned;
    return ST_DIRECT;
  endfunction

  function automatic status_t lookup_read(logic [31:0] addr);
    int unsigned n, lg, victim;
    logic [31:0] lba, aligned, oldest;
    n = used_tiles();
    lg = (size_r > MaxTileLog2) ? MaxTileLog2 : size_r;
    lba = addr;
    if (mode_r == 1) begin
      lba = addr + disp_r;
      if (lba < addr) return ST_ROLL;
    end else if (mode_r == 2) begin
      if (addr < disp_r) return ST_ROLL;
      lba = addr - disp_r;
    end
    aligned = lba & ~((32'd1 << lg) - 32'd1);
    for (int unsigned i = 0; i < n; i++) begin
      if (tag_ok[i] && tag_m[i] == aligned) begin
        touch_age(i);
        return ST_HIT;
      end
    end
    victim = 0;
    oldest = AgeLimit;
    for (int unsigned i = 0; i < n; i++) begin
      if (!tag_ok[i]) begin
        victim = i;
        break;
      end
      if (age_m[i] < oldest) begin
        oldest = age_m[i];
        victim = i;
      end
    end
    tag_ok[victim] = 1'b0;
    tag_m[victim] = '1;
    if (aerr_ok[victim] && aerr_m[victim] == aligned) return fill_failed(victim, lba, aligned);
    pend_kind = PEND_FILL;
    pend_tile = victim;
    pend_addr = lba;
    pend_aligned = aligned;
    return ST_FILL;
  endfunction

  function automatic status_t predict_status(logic [1:0] act, logic [31:0] addr, logic ok);
    if (act == ACT_READ) begin
      if (pend_kind == PEND_NONE) return lookup_read(addr);
    end else if (act == ACT_FILL && pend_kind == PEND_FILL) begin
      if (ok) begin
        tag_m[pend_tile] = pend_aligned;
        tag_ok[pend_tile] = 1'b1;
        touch_age(pend_tile);
        pend_kind = PEND_NONE;
        return ST_OK;
      end
      return fill_failed(pend_tile, pend_addr, pend_aligned);
    end else if (act == ACT_DIRECT && pend_kind == PEND_DIRECT) begin
      pend_kind = PEND_NONE;
      if (ok) return ST_OK;
      err_m[pend_tile] = pend_addr;
      err_ok[pend_tile] = 1'b1;
      return ST_MISHAP;
    end
    return ST_ORDER;
  endfunction

  task automatic send_item(logic [1:0] act, logic [31:0] addr, logic ok);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {5'd0, ok, addr, act};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    status_q.push_back(predict_status(act, addr, ok));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DISP:  disp_r = val;
      REG_MODE:  mode_r = val & 32'd3;
      REG_TILES: tiles_r = val & 32'd63;
      default:   size_r = val & 32'd7;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // read request followed by the device outcomes it asks for
  task automatic read_sequence(logic [31:0] addr);
    send_item(ACT_READ, addr, 1'($urandom_range(0, 1)));
    if (pend_kind == PEND_FILL) send_item(ACT_FILL, $urandom(), $urandom_range(0, 9) < 7);
    if (pend_kind == PEND_DIRECT) send_item(ACT_DIRECT, $urandom(), $urandom_range(0, 9) < 6);
  endtask

  task automatic test_hit_and_miss();
    send_item(ACT_READ, 32'h0000_0040, 1'b0);
    send_item(ACT_FILL, 32'h0, 1'b1);
    send_item(ACT_READ, 32'h0000_005f, 1'b0);   // same tile, hit
    send_item(ACT_READ, 32'hffff_ffff, 1'b1);
    send_item(ACT_FILL, 32'hffff_ffff, 1'b1);
    send_item(ACT_READ, 32'hffff_ffe0, 1'b0);
  endtask

  task automatic test_fill_fallback();
    send_item(ACT_READ, 32'h1234_5600, 1'b0);
    send_item(ACT_FILL, 32'h0, 1'b0);
    send_item(ACT_DIRECT, 32'h0, 1'b0);
    // known failing fill and direct read: no device read; a neighbouring address still reads direct
    send_item(ACT_READ, 32'h1234_5600, 1'b0);
    send_item(ACT_READ, 32'h1234_5601, 1'b0);
    send_item(ACT_DIRECT, 32'h0, 1'b1);
  endtask

  task automatic test_out_of_order();
    send_item(ACT_FILL, 32'h0, 1'b1);
    send_item(ACT_DIRECT, 32'h0, 1'b0);
    send_item(ActNone, 32'hffff_ffff, 1'b1);
    send_item(ACT_READ, 32'h0000_9000, 1'b0);
    send_item(ACT_READ, 32'h0000_9000, 1'b0);   // request while pending
    send_item(ACT_DIRECT, 32'h0, 1'b1);
    send_item(ACT_FILL, 32'h0, 1'b1);
  endtask

  task automatic test_rollover();
    write_reg(REG_DISP, 32'hffff_ffff);
    write_reg(REG_MODE, 32'd1);
    send_item(ACT_READ, 32'h0000_0001, 1'b0);
    send_item(ACT_READ, 32'h0000_0000, 1'b0);
    send_item(ACT_FILL, 32'h0, 1'b1);
    write_reg(REG_DISP, 32'd5);
    write_reg(REG_MODE, 32'd2);
    send_item(ACT_READ, 32'h0000_0004, 1'b0);
    send_item(ACT_READ, 32'h0000_0005, 1'b0);
    send_item(ACT_FILL, 32'h0, 1'b0);
    send_item(ACT_DIRECT, 32'h0, 1'b1);
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, 32'd0);
    hold_left = 400;
    for (int i = 0; i < 40; i++)
      send_item(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned sent;
    logic [31:0] addr;
    sent = 0;
    while (sent < count) begin
      no_idle = ($urandom_range(0, 15) == 0);
      addr = ($urandom_range(0, 9) == 0) ? $urandom()
                                         : addr_pool[$urandom_range(0, 47)] ^ $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 85) begin
        read_sequence(addr);
        sent += 2;
      end else begin
        send_item(2'($urandom_range(0, 3)), addr, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    write_reg(REG_DISP, $urandom());
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_TILES, 32'd8);
    write_reg(REG_SIZE, 32'd2);
    random_phase(200);
    write_reg(REG_MODE, 32'd2);
    write_reg(REG_TILES, 32'd1);
    write_reg(REG_SIZE, 32'd0);
    random_phase(150);
    write_reg(REG_MODE, 32'd3);
    write_reg(REG_TILES, 32'd0);
    write_reg(REG_SIZE, 32'd7);
    random_phase(150);
    write_reg(REG_DISP, 32'h0000_0100);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_TILES, 32'hffff_ffff);  // 63 in field, clamped
    write_reg(REG_SIZE, 32'd6);
    random_phase(250);
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_TILES, 32'd32);
    write_reg(REG_SIZE, 32'd5);
    random_phase(300);
    write_reg(REG_DISP, 32'hffff_ff00);
    write_reg(REG_MODE, 32'd2);
    write_reg(REG_TILES, 32'd3);
    write_reg(REG_SIZE, 32'd1);
    random_phase(200);
  endtask

  initial begin
    disp_r = 0;
    mode_r = 0;
    tiles_r = 32;
    size_r = 5;
    for (int i = 0; i < MaxTiles; i++) begin
      tag_m[i] = '1;
      tag_ok[i] = 1'b0;
      age_m[i] = 0;
      err_m[i] = '1;
      err_ok[i] = 1'b0;
      aerr_m[i] = '1;
      aerr_ok[i] = 1'b0;
    end
    age_cnt = 0;
    pend_kind = PEND_NONE;
    pend_tile = 0;
    pend_addr = 0;
    pend_aligned = 0;
    for (int i = 0; i < 48; i++) addr_pool[i] = $urandom();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    repeat (40) @(negedge clk);
    test_hit_and_miss();
    test_fill_fallback();
    test_out_of_order();
    test_rollover();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
